// ===== rtl/core/lkvc_pkg.sv =====
// Shared constants, types and controller/datapath signal groups for the LRU key-value cache.
package lkvc_pkg;

    localparam int LKVC_ENTRIES = 16;
    localparam int KEY_W        = 32;
    localparam int VAL_W        = 32;
    localparam int CAP_W        = 5;
    localparam int APB_DATA_W   = 32;
    localparam int LKVC_ADDR_W  = 3;

    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    // Register index, taken from the word address of the configuration port.
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_DRAIN,
        ST_DECIDE,
        ST_UPDATE,
        ST_UPDATE_DRAIN,
        ST_FINISH
    } lkvc_state_t;

    typedef struct packed {
        logic capture;
        logic scan_step;
        logic commit;
        logic upd_step;
        logic out_load;
    } lkvc_cmd_t;

    typedef struct packed {
        logic idx_last;
        logic is_put;
        logic hit;
        logic out_free;
    } lkvc_status_t;

endpackage

// ===== rtl/core/lkvc_req_if.sv =====
// Request channel: command, key and value with a valid/ready handshake.
interface lkvc_req_if import lkvc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output command, output key, output value, input ready);
    modport sink   (input valid, input command, input key, input value, output ready);
endinterface

// ===== rtl/core/lkvc_rsp_if.sv =====
// Response channel: found flag and read value with a valid/ready handshake.
interface lkvc_rsp_if import lkvc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    found;
    logic signed [VAL_W-1:0] read_value;

    modport source (output valid, output found, output read_value, input ready);
    modport sink   (input valid, input found, input read_value, output ready);
endinterface

// ===== rtl/core/lkvc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module lkvc_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/lkvc_ctrl.sv =====
// Sequencing state machine: scan pass, commit, rank update pass and result hand-off.
module lkvc_ctrl import lkvc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  lkvc_status_t status,
    output lkvc_cmd_t    cmd
);

    lkvc_state_t state_reg;
    lkvc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.idx_last)
                begin
                    state_next = ST_SCAN_DRAIN;
                end
            end
            ST_SCAN_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                // A get that missed leaves the ranks untouched.
                if (!status.is_put && !status.hit)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (status.idx_last)
                begin
                    state_next = ST_UPDATE_DRAIN;
                end
            end
            ST_UPDATE_DRAIN:
            begin
                state_next = status.is_put ? ST_IDLE : ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ST_DECIDE:
            begin
                cmd.commit = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.upd_step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    a_decide_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DECIDE |-> $past(state_reg) == ST_SCAN_DRAIN)
        else $error("commit reached without a completed scan");

    a_scan_follows_capture: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == ST_SCAN)
        else $error("captured beat did not start a scan");

endmodule

// ===== rtl/core/lkvc_dp.sv =====
// Datapath: entry memories, valid bits, scan trackers, rank update and result register.
module lkvc_dp import lkvc_pkg::*; #(
    parameter int ENTRIES = LKVC_ENTRIES
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lkvc_cmd_t               cmd,
    output lkvc_status_t            status,
    input  logic                    clear,
    input  logic [CAP_W-1:0]        capacity,
    input  logic                    in_command,
    input  logic signed [KEY_W-1:0] in_key,
    input  logic signed [VAL_W-1:0] in_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    out_found,
    output logic signed [VAL_W-1:0] out_read_value
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int THR_W = IDX_W + 1;

    // Control state
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               pipe_scan_reg, pipe_upd_reg;
    logic               hit_reg, hit_next;
    logic               free_found_reg, free_found_next;
    logic               out_valid_reg, out_valid_next;

    // Payload
    logic               cmd_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VAL_W-1:0]   val_reg;
    logic [IDX_W-1:0]   pipe_idx_reg;
    logic [IDX_W-1:0]   hit_slot_reg, hit_slot_next;
    logic [IDX_W-1:0]   hit_rank_reg, hit_rank_next;
    logic [VAL_W-1:0]   hit_val_reg, hit_val_next;
    logic [IDX_W-1:0]   free_slot_reg, free_slot_next;
    logic [IDX_W-1:0]   vict_slot_reg, vict_slot_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [THR_W-1:0]   thresh_reg, thresh_next;
    logic               out_found_reg;
    logic [VAL_W-1:0]   out_value_reg;

    // Memory ports
    logic [KEY_W-1:0]   key_rd;
    logic [VAL_W-1:0]   val_rd;
    logic [IDX_W-1:0]   rank_rd;
    logic               key_we, val_we, rank_we;
    logic [IDX_W-1:0]   rank_wdata;

    logic [CNT_W-1:0]   eff_cap;
    logic               idx_last;
    logic               entry_valid;
    logic               key_match;
    logic               vict_match;
    logic               evict;
    logic [IDX_W-1:0]   commit_slot;

    lkvc_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .clk     (clk),
        .wr_en   (key_we),
        .wr_addr (commit_slot),
        .wr_data (key_reg),
        .rd_addr (idx_reg),
        .rd_data (key_rd)
    );

    lkvc_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
        .clk     (clk),
        .wr_en   (val_we),
        .wr_addr (commit_slot),
        .wr_data (val_reg),
        .rd_addr (idx_reg),
        .rd_data (val_rd)
    );

    lkvc_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_rank_ram (
        .clk     (clk),
        .wr_en   (rank_we),
        .wr_addr (pipe_idx_reg),
        .wr_data (rank_wdata),
        .rd_addr (idx_reg),
        .rd_data (rank_rd)
    );

    always_comb
    begin
        if (capacity == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (32'(capacity) > 32'(ENTRIES))
        begin
            eff_cap = CNT_W'(ENTRIES);
        end
        else
        begin
            eff_cap = CNT_W'(capacity);
        end
    end

    assign idx_last    = (idx_reg == IDX_W'(ENTRIES - 1));
    assign entry_valid = valid_reg[pipe_idx_reg];
    assign key_match   = entry_valid && (key_rd == key_reg);
    // The least recent entry holds the highest rank, count - 1.
    assign vict_match  = entry_valid && (CNT_W'(rank_rd) == count_reg - CNT_W'(1));
    assign evict       = (count_reg >= eff_cap);
    assign commit_slot = hit_reg ? hit_slot_reg : (evict ? vict_slot_reg : free_slot_reg);

    assign key_we = cmd.commit && cmd_reg && !hit_reg;
    assign val_we = cmd.commit && cmd_reg;

    // Second pass: the touched or inserted slot becomes rank zero, and every other valid
    // entry more recent than the threshold ages by one.
    always_comb
    begin
        rank_we    = 1'b0;
        rank_wdata = rank_rd + IDX_W'(1);
        if (pipe_upd_reg)
        begin
            if (pipe_idx_reg == slot_reg)
            begin
                rank_we    = 1'b1;
                rank_wdata = '0;
            end
            else if (entry_valid && (THR_W'(rank_rd) < thresh_reg))
            begin
                rank_we = 1'b1;
            end
        end
    end

    always_comb
    begin
        valid_next      = valid_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        hit_next        = hit_reg;
        free_found_next = free_found_reg;
        hit_slot_next   = hit_slot_reg;
        hit_rank_next   = hit_rank_reg;
        hit_val_next    = hit_val_reg;
        free_slot_next  = free_slot_reg;
        vict_slot_next  = vict_slot_reg;
        slot_next       = slot_reg;
        thresh_next     = thresh_reg;
        out_valid_next  = out_valid_reg;

        if (cmd.capture || cmd.commit)
        begin
            idx_next = '0;
        end
        else if (cmd.scan_step || cmd.upd_step)
        begin
            idx_next = idx_last ? '0 : idx_reg + IDX_W'(1);
        end

        if (cmd.capture)
        begin
            hit_next        = 1'b0;
            free_found_next = 1'b0;
        end

        if (pipe_scan_reg)
        begin
            if (key_match && !hit_reg)
            begin
                hit_next      = 1'b1;
                hit_slot_next = pipe_idx_reg;
                hit_rank_next = rank_rd;
                hit_val_next  = val_rd;
            end
            if (!entry_valid && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_slot_next  = pipe_idx_reg;
            end
            if (vict_match)
            begin
                vict_slot_next = pipe_idx_reg;
            end
        end

        if (cmd.commit)
        begin
            slot_next = commit_slot;
            if (hit_reg)
            begin
                thresh_next = THR_W'(hit_rank_reg);
            end
            else
            begin
                thresh_next = THR_W'(ENTRIES);
                if (cmd_reg)
                begin
                    valid_next[commit_slot] = 1'b1;
                    if (!evict)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
        end

        if (clear)
        begin
            valid_next = '0;
            count_next = '0;
        end

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            pipe_scan_reg  <= 1'b0;
            pipe_upd_reg   <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            pipe_scan_reg  <= cmd.scan_step;
            pipe_upd_reg   <= cmd.upd_step;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg <= in_command;
            key_reg <= in_key;
            val_reg <= in_value;
        end
        pipe_idx_reg  <= idx_reg;
        hit_slot_reg  <= hit_slot_next;
        hit_rank_reg  <= hit_rank_next;
        hit_val_reg   <= hit_val_next;
        free_slot_reg <= free_slot_next;
        vict_slot_reg <= vict_slot_next;
        slot_reg      <= slot_next;
        thresh_reg    <= thresh_next;
        if (cmd.out_load)
        begin
            out_found_reg <= hit_reg;
            out_value_reg <= hit_reg ? hit_val_reg : MISS_VALUE;
        end
    end

    assign status.idx_last = idx_last;
    assign status.is_put   = cmd_reg;
    assign status.hit      = hit_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign out_found      = out_found_reg;
    assign out_read_value = out_value_reg;

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("entry count differs from the number of valid entries");

    a_count_within_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= eff_cap)
        else $error("entry count exceeds the effective capacity");

endmodule

// ===== rtl/core/lru_key_value_cache_core.sv =====
// LRU key-value cache top level: configuration register and controller/datapath wiring.
//
// A fully associative store of ENTRIES key-value pairs with least-recently-used
// replacement. A get beat returns one response (found and the stored value, or
// not found with all ones); a put beat returns nothing and updates or inserts.
// Items are handled one at a time. Each item makes a scan pass that reads every
// slot of the key, value and rank memories through their single read port, one
// slot per cycle. A put and a get that hits then make a second pass, the
// read-modify-write of the rank memory; a get that misses skips it. A finished
// response waits in an output register, so the next request is taken while it
// is still pending; a get then holds in its final state for as long as the
// response before it has not been taken. Writing the capacity register (byte
// address 0) empties the store at once; capacity zero behaves as one and values
// above ENTRIES as ENTRIES.
module lru_key_value_cache_core import lkvc_pkg::*; #(
    parameter int ENTRIES = LKVC_ENTRIES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    lkvc_req_if.sink               req,
    lkvc_rsp_if.source             rsp,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [LKVC_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    logic [CAP_W-1:0] capacity_reg, capacity_next;
    logic             reg_sel;
    logic             cfg_write;
    lkvc_cmd_t        cmd;
    lkvc_status_t     status;

    assign reg_sel   = paddr[LKVC_ADDR_W-1];
    assign cfg_write = psel && penable && pwrite && (reg_sel == REG_CAPACITY);
    assign pready    = 1'b1;

    always_comb
    begin
        capacity_next = capacity_reg;
        if (cfg_write)
        begin
            capacity_next = pwdata[CAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_CAPACITY: prdata = APB_DATA_W'(capacity_reg);
            default:      prdata = '0;
        endcase
    end

    lkvc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    lkvc_dp #(.ENTRIES(ENTRIES)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .clear          (cfg_write),
        .capacity       (capacity_reg),
        .in_command     (req.command),
        .in_key         (req.key),
        .in_value       (req.value),
        .out_valid      (rsp.valid),
        .out_ready      (rsp.ready),
        .out_found      (rsp.found),
        .out_read_value (rsp.read_value)
    );

endmodule
